>>> src/current_loop_pressure_scaler_unit_assert.svh
// Assertion macros shared by the current loop pressure scaler RTL.
`ifndef CURRENT_LOOP_PRESSURE_SCALER_UNIT_ASSERT_SVH
`define CURRENT_LOOP_PRESSURE_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CLPSS_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CLPSS_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/clpss_pkg.sv
// Shared types and constants of the current loop pressure scaler.
`default_nettype none
package clpss_pkg;

	// Field widths.
	localparam int unsigned MV_W     = 16;
	localparam int unsigned SHUNT_W  = 20;
	localparam int unsigned FS_W     = 14;
	localparam int unsigned TOL_W    = 7;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned PRESS_W  = 30;
	localparam int unsigned UA_W     = 36;
	localparam int unsigned DIVN_W   = 38;
	localparam int unsigned CNT_W    = 6;

	// Loop and scaling constants.
	localparam int unsigned UA_MIN      = 4000;
	localparam int unsigned UA_MAX      = 20000;
	localparam int unsigned UA_SPAN     = UA_MAX - UA_MIN;
	localparam int unsigned MV_SCALE    = 1000000;
	localparam int unsigned PCT         = 100;
	localparam int unsigned LO_STEP     = UA_MIN / PCT;
	localparam int unsigned HI_STEP     = UA_MAX / PCT;
	// 68948/16000 reduced to 17237/4000; 4000 is split into 32 * 125.
	localparam int unsigned SCALE_NUM   = 17237;
	localparam int unsigned SCALE_SHIFT = 5;
	localparam int unsigned SCALE_DIV   = 125;
	localparam int unsigned ITERS_CUR   = UA_W;
	localparam int unsigned ITERS_PRS   = 31;

	// Register reset values.
	localparam logic [SHUNT_W-1:0] SHUNT_RST = 20'd250000;
	localparam logic [FS_W-1:0]    FS_RST    = 14'd100;
	localparam logic [TOL_W-1:0]   TOL_RST   = 7'd5;

	// Register indexes.
	localparam logic [1:0] REG_SHUNT = 2'd0;
	localparam logic [1:0] REG_FS    = 2'd1;
	localparam logic [1:0] REG_TOL   = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_UNDER = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_OVER  = 2'd2;

	typedef struct packed {
		logic [SHUNT_W-1:0] shunt_milliohm;
		logic [FS_W-1:0]    full_scale_psi;
		logic [TOL_W-1:0]   tolerance_pct;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [CNT_W-1:0]   iters;
		logic [DIVN_W-1:0]  dividend;
		logic [SHUNT_W-1:0] rem_init;
		logic [SHUNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              last;
		logic [DIVN_W-1:0] quot;
	} div_rsp_t;

endpackage
`default_nettype wire

>>> src/clpss_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module clpss_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output clpss_pkg::cfg_t         cfg
);
	import clpss_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Register writes, decoded on the word index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shunt_milliohm <= SHUNT_RST;
			cfg_q.full_scale_psi <= FS_RST;
			cfg_q.tolerance_pct  <= TOL_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_SHUNT: cfg_q.shunt_milliohm <= pwdata[SHUNT_W-1:0];
				REG_FS:    cfg_q.full_scale_psi <= pwdata[FS_W-1:0];
				REG_TOL:   cfg_q.tolerance_pct  <= pwdata[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read mux; unmapped words read as zero.
	always_comb begin
		unique case (paddr[3:2])
			REG_SHUNT: prdata = 32'(cfg_q.shunt_milliohm);
			REG_FS:    prdata = 32'(cfg_q.full_scale_psi);
			REG_TOL:   prdata = 32'(cfg_q.tolerance_pct);
			default:   prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

>>> src/clpss_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module clpss_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  clpss_pkg::div_req_t  req,
	output clpss_pkg::div_rsp_t  rsp
);
	import clpss_pkg::*;

	logic [DIVN_W-1:0]  num_q;
	logic [SHUNT_W-1:0] rem_q;
	logic [SHUNT_W-1:0] dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [SHUNT_W+1:0] trial;
	logic               qbit;
	logic [SHUNT_W-1:0] rem_nxt;

	// One restoring step: bring in the next dividend bit and try to subtract.
	always_comb begin
		trial   = {1'b0, rem_q, num_q[DIVN_W-1]} - {2'b00, dvs_q};
		qbit    = ~trial[SHUNT_W+1];
		rem_nxt = qbit ? trial[SHUNT_W-1:0] : {rem_q[SHUNT_W-2:0], num_q[DIVN_W-1]};
	end

	// Control: iteration count and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: the dividend shifts out at the top while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= req.rem_init;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIVN_W-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.last = busy_q & (cnt_q == CNT_W'(1));
	assign rsp.quot = num_q;
endmodule
`default_nettype wire

>>> src/current_loop_pressure_scaler_unit.sv
// Top level of the current loop pressure scaler: sequencer, scaling and result register.
//
// Usage: each beat on the s_axis channel carries one shunt voltage in millivolts.
// The block turns it into loop current (mV * 1000000 / shunt) with a bit-serial
// divider, checks it against the fault limits set by tolerance_pct, and for a
// good reading clamps it to 4..20 mA and scales it to milli-hPa with a second
// serial divide. Each input beat gives exactly one m_axis beat: tuser holds the
// status, tdata the pressure (held from the last good reading on a fault).
// A good reading runs the current divide, the range check, the multiply, the
// pressure divide and the result step; a fault goes from the check straight to
// the result step. Only one item is in work at a time, and the sequencer takes
// the next beat in its idle state, so a new sample is not taken before the last
// one has left the sequencer; both divides share one divider.
// The finished result waits in the output register, so the next sample is taken
// while the receiver stalls; a second result waits in the sequencer until the
// output register frees up. Reset clears all control state, restores the register
// reset values and sets the held pressure to zero. The user must write configuration
// over the APB-style port only while no item is in work; the block does not enforce it.
`default_nettype none
module current_loop_pressure_scaler_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_mv
	// Output stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [29:0] pressure_milli_hpa, [31:30] zero
	output logic [1:0]       m_axis_tuser    // [1:0] status
);
	import clpss_pkg::*;

	`include "current_loop_pressure_scaler_unit_assert.svh"

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV1  = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_DIV2  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t              state_q;
	state_t              state_nxt;
	cfg_t                cfg;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                in_acc;
	logic                out_load;
	logic [UA_W-1:0]     num_w;
	logic [UA_W-1:0]     ua;
	logic [TOL_W-1:0]    pct_diff;
	logic [TOL_W:0]      pct_sum;
	logic [11:0]         lo_lim;
	logic [15:0]         hi_lim;
	logic [STAT_W-1:0]   status_w;
	logic [FS_W-1:0]     span_w;
	logic [42:0]         m2_w;
	logic [DIVN_W-1:0]   scaled_w;
	logic [PRESS_W:0]    p_raw;
	logic [PRESS_W-1:0]  p_sat;

	logic [STAT_W-1:0]   status_q;
	logic [27:0]         m1_q;
	logic [PRESS_W-1:0]  held_pressure_q;
	logic                out_valid_q;
	logic [STAT_W-1:0]   out_status_q;
	logic [PRESS_W-1:0]  out_press_q;

	clpss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	clpss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_load      = (state_q == ST_FIN) & (~out_valid_q | m_axis_tready);

	// Numerator of the current divide: millivolts times one million.
	assign num_w = UA_W'(s_axis_tdata) * UA_W'(MV_SCALE);

	// Pressure path: span times full scale times 17237, then divide by 32 and by 125.
	assign m2_w     = 43'(m1_q) * 43'(SCALE_NUM);
	assign scaled_w = m2_w[42:SCALE_SHIFT];

	// Divider requests: current divide on input, pressure divide after the multiply.
	always_comb begin
		div_req.start = in_acc | (state_q == ST_MUL);
		if (state_q == ST_MUL) begin
			div_req.iters    = CNT_W'(ITERS_PRS);
			div_req.dividend = {scaled_w[ITERS_PRS-1:0], (DIVN_W - ITERS_PRS)'(0)};
			div_req.rem_init = SHUNT_W'(scaled_w[DIVN_W-1:ITERS_PRS]);
			div_req.divisor  = SHUNT_W'(SCALE_DIV);
		end else begin
			div_req.iters    = CNT_W'(ITERS_CUR);
			div_req.dividend = {num_w, (DIVN_W - UA_W)'(0)};
			div_req.rem_init = '0;
			div_req.divisor  = cfg.shunt_milliohm;
		end
	end

	// Fault limits, range check and clamped current span.
	always_comb begin
		ua       = div_rsp.quot[UA_W-1:0];
		pct_diff = TOL_W'(PCT) - cfg.tolerance_pct;
		pct_sum  = (TOL_W+1)'(PCT) + (TOL_W+1)'(cfg.tolerance_pct);
		lo_lim   = (cfg.tolerance_pct >= TOL_W'(PCT)) ? 12'd0
		         : 12'(pct_diff) * 12'(LO_STEP);
		hi_lim   = 16'(pct_sum) * 16'(HI_STEP);
		status_w = STATUS_OK;
		span_w   = '0;
		priority if (ua < UA_W'(lo_lim)) begin
			status_w = STATUS_UNDER;
		end else if (ua < UA_W'(UA_MIN)) begin
			span_w = '0;
		end else if (ua > UA_W'(hi_lim)) begin
			status_w = STATUS_OVER;
		end else if (ua > UA_W'(UA_MAX)) begin
			span_w = FS_W'(UA_SPAN);
		end else begin
			span_w = FS_W'(ua[14:0] - 15'(UA_MIN));
		end
	end

	// Pressure quotient, saturated to the field width.
	assign p_raw = div_rsp.quot[PRESS_W:0];
	assign p_sat = p_raw[PRESS_W] ? '1 : p_raw[PRESS_W-1:0];

	// Sequencer.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_nxt = ST_DIV1;
			end
			ST_DIV1: begin
				if (div_rsp.last) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				state_nxt = (status_w == STATUS_OK) ? ST_MUL : ST_FIN;
			end
			ST_MUL: begin
				state_nxt = ST_DIV2;
			end
			ST_DIV2: begin
				if (div_rsp.last) state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (out_load) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Status and first product, captured after the range check.
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			status_q <= status_w;
			m1_q     <= 28'(span_w) * 28'(cfg.full_scale_psi);
		end
	end

	// Held pressure follows every good reading.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_pressure_q <= '0;
		end else if (out_load && status_q == STATUS_OK) begin
			held_pressure_q <= p_sat;
		end
	end

	// Output register: loads a finished result, frees when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_press_q  <= (status_q == STATUS_OK) ? p_sat : held_pressure_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = 32'(out_press_q);

	// The divider starts on the cycle after an input beat is taken.
	`CLPSS_ASSERT_NXT(a_div_starts, clk, arst_n, in_acc, div_rsp.busy, "divider idle after input beat")
	// No division may be running while the sequencer is idle.
	`CLPSS_ASSERT_IMP(a_idle_div, clk, arst_n, state_q == ST_IDLE, !div_rsp.busy, "divider busy in idle")
	// A fault result leaves the held pressure untouched.
	`CLPSS_ASSERT_NXT(a_fault_hold, clk, arst_n, out_load && status_q != STATUS_OK, $stable(held_pressure_q), "held pressure changed on fault")
	// Only defined status codes are presented.
	`CLPSS_ASSERT_IMP(a_status_code, clk, arst_n, m_axis_tvalid, m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_UNDER || m_axis_tuser == STATUS_OVER, "undefined status code")
endmodule
`default_nettype wire
